// ===== hdl/yuvbgr_pkg.sv =====
// Shared widths, register codes, reset values and types of the YUV to BGR converter.
package yuvbgr_pkg;

	localparam int PIX_W      = 8;
	localparam int COEF_W     = 15;
	localparam int DIFF_W     = PIX_W + 1;
	localparam int PROD_W     = COEF_W + 1 + DIFF_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COEF_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLUE_FROM_U   = 3'd0,
		REG_GREEN_FROM_U  = 3'd1,
		REG_GREEN_FROM_V  = 3'd2,
		REG_RED_FROM_V    = 3'd3,
		REG_CHROMA_OFFSET = 3'd4
	} cfg_reg_t;

	localparam logic [COEF_W-1:0] RESET_BLUE_FROM_U   = 15'd28384;
	localparam logic [COEF_W-1:0] RESET_GREEN_FROM_U  = 15'd11436;
	localparam logic [COEF_W-1:0] RESET_GREEN_FROM_V  = 15'd11520;
	localparam logic [COEF_W-1:0] RESET_RED_FROM_V    = 15'd22458;
	localparam logic [PIX_W-1:0]  RESET_CHROMA_OFFSET = 8'd128;

	typedef struct packed {
		logic [COEF_W-1:0] blue_from_u;
		logic [COEF_W-1:0] green_from_u;
		logic [COEF_W-1:0] green_from_v;
		logic [COEF_W-1:0] red_from_v;
		logic [PIX_W-1:0]  chroma_offset;
	} cfg_t;

	// Load enables of the four pipeline stages.
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctl_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] blue_u;
		logic signed [PROD_W-1:0] green_u;
		logic signed [PROD_W-1:0] green_v;
		logic signed [PROD_W-1:0] red_v;
	} prod_t;

endpackage

// ===== hdl/yuvbgr_cfg.sv =====
// Configuration register file of the YUV to BGR converter.
module yuvbgr_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [yuvbgr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [yuvbgr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output yuvbgr_pkg::cfg_t                   cfg
);
	import yuvbgr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blue_from_u   <= RESET_BLUE_FROM_U;
			cfg_q.green_from_u  <= RESET_GREEN_FROM_U;
			cfg_q.green_from_v  <= RESET_GREEN_FROM_V;
			cfg_q.red_from_v    <= RESET_RED_FROM_V;
			cfg_q.chroma_offset <= RESET_CHROMA_OFFSET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLUE_FROM_U:   cfg_q.blue_from_u   <= cfg_data;
				REG_GREEN_FROM_U:  cfg_q.green_from_u  <= cfg_data;
				REG_GREEN_FROM_V:  cfg_q.green_from_v  <= cfg_data;
				REG_RED_FROM_V:    cfg_q.red_from_v    <= cfg_data;
				REG_CHROMA_OFFSET: cfg_q.chroma_offset <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/yuvbgr_mul.sv =====
// Stages one and two: chroma offset removal, then the four coefficient products.
module yuvbgr_mul (
	input  logic                           clk,
	input  yuvbgr_pkg::pipe_ctl_t          ctl,
	input  yuvbgr_pkg::cfg_t               cfg,
	input  logic [yuvbgr_pkg::PIX_W-1:0]   luma,
	input  logic [yuvbgr_pkg::PIX_W-1:0]   chroma_u,
	input  logic [yuvbgr_pkg::PIX_W-1:0]   chroma_v,
	output logic [yuvbgr_pkg::PIX_W-1:0]   luma_out,
	output yuvbgr_pkg::prod_t              prod
);
	import yuvbgr_pkg::*;

	logic [PIX_W-1:0]         luma_s1;
	logic signed [DIFF_W-1:0] du_s1;
	logic signed [DIFF_W-1:0] dv_s1;
	logic [PIX_W-1:0]         luma_s2;
	prod_t                    prod_s2;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			luma_s1 <= luma;
			du_s1   <= $signed({1'b0, chroma_u}) - $signed({1'b0, cfg.chroma_offset});
			dv_s1   <= $signed({1'b0, chroma_v}) - $signed({1'b0, cfg.chroma_offset});
		end
	end

	// Coefficients are unsigned, so a zero is prepended before the signed multiply.
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			luma_s2         <= luma_s1;
			prod_s2.blue_u  <= $signed({1'b0, cfg.blue_from_u}) * du_s1;
			prod_s2.green_u <= $signed({1'b0, cfg.green_from_u}) * du_s1;
			prod_s2.green_v <= $signed({1'b0, cfg.green_from_v}) * dv_s1;
			prod_s2.red_v   <= $signed({1'b0, cfg.red_from_v}) * dv_s1;
		end
	end

	assign luma_out = luma_s2;
	assign prod     = prod_s2;

endmodule

// ===== hdl/yuvbgr_sum.sv =====
// Stages three and four: colour sums, then scaling and clamping to bytes.
module yuvbgr_sum #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                           clk,
	input  yuvbgr_pkg::pipe_ctl_t          ctl,
	input  logic [yuvbgr_pkg::PIX_W-1:0]   luma,
	input  yuvbgr_pkg::prod_t              prod,
	output logic [yuvbgr_pkg::PIX_W-1:0]   blue,
	output logic [yuvbgr_pkg::PIX_W-1:0]   green,
	output logic [yuvbgr_pkg::PIX_W-1:0]   red
);
	import yuvbgr_pkg::*;

	localparam int SUM_W = COEF_FRAC_BITS + 18;

	logic signed [SUM_W-1:0] base;
	logic signed [SUM_W-1:0] p_bu;
	logic signed [SUM_W-1:0] p_gu;
	logic signed [SUM_W-1:0] p_gv;
	logic signed [SUM_W-1:0] p_rv;
	logic signed [SUM_W-1:0] blue_s3;
	logic signed [SUM_W-1:0] green_s3;
	logic signed [SUM_W-1:0] red_s3;
	logic [PIX_W-1:0]        blue_s4;
	logic [PIX_W-1:0]        green_s4;
	logic [PIX_W-1:0]        red_s4;

	// A negative sum gives a quotient of zero or below, so truncation toward zero
	// and the lower clamp together give zero; otherwise the quotient is a plain shift.
	function automatic logic [PIX_W-1:0] clamp(input logic signed [SUM_W-1:0] acc);
		logic [PIX_W-1:0] res;
		if (acc[SUM_W-1])
			res = '0;
		else if (|acc[SUM_W-2:COEF_FRAC_BITS+PIX_W])
			res = '1;
		else
			res = acc[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
		return res;
	endfunction

	always_comb begin
		base = $signed({{(SUM_W-PIX_W-COEF_FRAC_BITS){1'b0}}, luma, {COEF_FRAC_BITS{1'b0}}});
		p_bu = $signed({{(SUM_W-PROD_W){prod.blue_u[PROD_W-1]}}, prod.blue_u});
		p_gu = $signed({{(SUM_W-PROD_W){prod.green_u[PROD_W-1]}}, prod.green_u});
		p_gv = $signed({{(SUM_W-PROD_W){prod.green_v[PROD_W-1]}}, prod.green_v});
		p_rv = $signed({{(SUM_W-PROD_W){prod.red_v[PROD_W-1]}}, prod.red_v});
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			blue_s3  <= base + p_bu;
			green_s3 <= base - p_gu - p_gv;
			red_s3   <= base + p_rv;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			blue_s4  <= clamp(blue_s3);
			green_s4 <= clamp(green_s3);
			red_s4   <= clamp(red_s3);
		end
	end

	assign blue  = blue_s4;
	assign green = green_s4;
	assign red   = red_s4;

endmodule

// ===== hdl/yuv_to_bgr_pixel_converter.sv =====
// Top level of the YUV to BGR pixel converter.
//
// Usage: one pixel enters per item on the slave stream (s_tdata holds luma,
// chroma_u and chroma_v) and one item leaves on the master stream with the
// blue, green and red bytes. Each colour is luma scaled by 2^COEF_FRAC_BITS
// plus or minus coefficient products on the offset-removed chroma, divided by
// 2^COEF_FRAC_BITS truncating toward zero and clamped to 0..255.
// The coefficient and offset registers are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while no item is in flight,
// which the block does not enforce. Indices above four are ignored. Each item
// passes chroma offset removal, one 16x9 multiply per product, the colour
// sums, then scale and clamp, each behind its own register. Throughput is
// one item per cycle while s_tready stays high. Reset clears every stage's
// valid bit and returns the registers to their package reset values. When
// the receiver holds m_tready low, the output register keeps its item, and
// each stage behind it still fills any empty slot ahead of it, so s_tready
// falls only once all four stages hold items. No item is dropped or repeated.
module yuv_to_bgr_pixel_converter #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Input stream.
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [23:0]                        s_tdata,   // luma, chroma_u, chroma_v
	// Output stream.
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [23:0]                        m_tdata,   // blue, green, red
	// Configuration writes.
	input  logic                               cfg_we,
	input  logic [yuvbgr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [yuvbgr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import yuvbgr_pkg::*;

	cfg_t             cfg;
	pipe_ctl_t        ctl;
	logic             valid_s1;
	logic             valid_s2;
	logic             valid_s3;
	logic             valid_s4;
	logic [PIX_W-1:0] luma_s2;
	prod_t            prod_s2;
	logic [PIX_W-1:0] blue;
	logic [PIX_W-1:0] green;
	logic [PIX_W-1:0] red;

	// A stage loads whenever it is empty or the stage after it moves on.
	always_comb begin
		ctl.en_s4 = !valid_s4 || m_tready;
		ctl.en_s3 = !valid_s3 || ctl.en_s4;
		ctl.en_s2 = !valid_s2 || ctl.en_s3;
		ctl.en_s1 = !valid_s1 || ctl.en_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ctl.en_s1) valid_s1 <= s_tvalid;
			if (ctl.en_s2) valid_s2 <= valid_s1;
			if (ctl.en_s3) valid_s3 <= valid_s2;
			if (ctl.en_s4) valid_s4 <= valid_s3;
		end
	end

	yuvbgr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	yuvbgr_mul u_mul (
		.clk      (clk),
		.ctl      (ctl),
		.cfg      (cfg),
		.luma     (s_tdata[7:0]),
		.chroma_u (s_tdata[15:8]),
		.chroma_v (s_tdata[23:16]),
		.luma_out (luma_s2),
		.prod     (prod_s2)
	);

	yuvbgr_sum #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_sum (
		.clk   (clk),
		.ctl   (ctl),
		.luma  (luma_s2),
		.prod  (prod_s2),
		.blue  (blue),
		.green (green),
		.red   (red)
	);

	assign s_tready = ctl.en_s1;
	assign m_tvalid = valid_s4;
	assign m_tdata  = {red, green, blue};

endmodule
